// ----- rtl/poq_pkg.sv -----
// ----------------------------------------------------------------------------
// poq_pkg: shared types and constants of the priority-ordered process queue
// action and status codes, controller states, command and status bundles
// ----------------------------------------------------------------------------
package poq_pkg;

	localparam int QUEUE_DEPTH_DEF   = 32;
	localparam int PRIORITY_BITS_DEF = 8;
	localparam int ID_W              = 5;
	localparam int ACTION_W          = 2;
	localparam int STATUS_W          = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT   = 2'd0,
		ACT_REM_HEAD = 2'd1,
		ACT_REM_ID   = 2'd2,
		ACT_PEEK     = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_REM,
		S_PEEK,
		S_FINISH
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_op;    // latch the request, set up the walk
		logic ins_run;    // insert walk, tail toward head
		logic rem_run;    // remove walk, head toward tail
		logic res_full;   // result: queue full
		logic res_empty;  // result: queue empty
		logic res_peek;   // result: head entry
		logic push_out;   // load the output register
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic ins_done;
		logic rem_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/poq_ctrl.sv -----
// ----------------------------------------------------------------------------
// poq_ctrl: request sequencer
// takes one request at a time and steps the datapath through its walk
// ----------------------------------------------------------------------------
module poq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [poq_pkg::ACTION_W-1:0]  action,
	input  poq_pkg::dp_stat_t             stat,
	output poq_pkg::dp_cmd_t              cmd
);
	import poq_pkg::*;

	state_t  state_q;
	state_t  state_d;
	action_t act;

	assign act = action_t'(action);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_op = 1'b1;
					unique case (act)
						ACT_INSERT: begin
							if (stat.full) begin
								cmd.res_full = 1'b1;
								state_d      = S_FINISH;
							end else begin
								state_d = S_INS;
							end
						end
						ACT_REM_HEAD, ACT_REM_ID: begin
							if (stat.empty) begin
								cmd.res_empty = 1'b1;
								state_d       = S_FINISH;
							end else begin
								state_d = S_REM;
							end
						end
						ACT_PEEK: begin
							if (stat.empty) begin
								cmd.res_empty = 1'b1;
								state_d       = S_FINISH;
							end else begin
								state_d = S_PEEK;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS: begin
				cmd.ins_run = 1'b1;
				if (stat.ins_done) begin
					state_d = S_FINISH;
				end
			end
			S_REM: begin
				cmd.rem_run = 1'b1;
				if (stat.rem_done) begin
					state_d = S_FINISH;
				end
			end
			S_PEEK: begin
				cmd.res_peek = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.push_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/poq_dp.sv -----
// ----------------------------------------------------------------------------
// poq_dp: queue storage and walk datapath
// slot memory with one write and one registered read port, walk pointers,
// result and output registers
// ----------------------------------------------------------------------------
module poq_dp #(
	parameter int QUEUE_DEPTH   = poq_pkg::QUEUE_DEPTH_DEF,
	parameter int PRIORITY_BITS = poq_pkg::PRIORITY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  poq_pkg::dp_cmd_t              cmd,
	output poq_pkg::dp_stat_t             stat,
	input  logic [poq_pkg::ACTION_W-1:0]  action,
	input  logic [poq_pkg::ID_W-1:0]      entry_id,
	input  logic [PRIORITY_BITS-1:0]      entry_priority,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [poq_pkg::STATUS_W-1:0]  status,
	output logic [poq_pkg::ID_W-1:0]      result_id,
	output logic [PRIORITY_BITS-1:0]      result_priority,
	output logic                          queue_empty
);
	import poq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// slot memory
	logic [ID_W-1:0]          id_mem   [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] prio_mem [QUEUE_DEPTH];

	logic [ID_W-1:0]          rd_id_s1;
	logic [PRIORITY_BITS-1:0] rd_prio_s1;
	logic [AW-1:0]            addr_s1;
	logic                     vld_s1;

	logic [CW-1:0]            occ_q;
	logic [AW-1:0]            hole_q;
	logic [CW-1:0]            ptr_q;
	logic                     found_q;
	logic [ID_W-1:0]          op_id_q;
	logic [PRIORITY_BITS-1:0] op_prio_q;
	logic                     op_head_q;

	status_t                  res_status_q;
	logic [ID_W-1:0]          res_id_q;
	logic [PRIORITY_BITS-1:0] res_prio_q;

	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [ID_W-1:0]          out_id_q;
	logic [PRIORITY_BITS-1:0] out_prio_q;
	logic                     out_empty_q;

	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [ID_W-1:0]          wr_id;
	logic [PRIORITY_BITS-1:0] wr_prio;
	logic                     shift_ins;
	logic                     ins_done;
	logic                     rem_done;
	logic                     rem_match;

	assign shift_ins = vld_s1 && (op_prio_q > rd_prio_s1);
	assign ins_done  = cmd.ins_run && (vld_s1 ? !shift_ins : (hole_q == '0));
	assign rem_done  = cmd.rem_run && !vld_s1 && (ptr_q == occ_q);
	assign rem_match = cmd.rem_run && vld_s1 && !found_q
		&& (op_head_q || (rd_id_s1 == op_id_q));

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = hole_q;
		wr_id   = op_id_q;
		wr_prio = op_prio_q;
		if (cmd.ins_run) begin
			if (vld_s1) begin
				wr_en = 1'b1;
				if (shift_ins) begin
					// move the lower entry one slot toward the tail
					wr_id   = rd_id_s1;
					wr_prio = rd_prio_s1;
					if (hole_q != AW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = hole_q - AW'(2);
					end
				end
			end else if (hole_q != '0) begin
				rd_en   = 1'b1;
				rd_addr = hole_q - AW'(1);
			end else begin
				wr_en = 1'b1;
			end
		end else if (cmd.rem_run) begin
			if (ptr_q < occ_q) begin
				rd_en   = 1'b1;
				rd_addr = ptr_q[AW-1:0];
			end
			if (vld_s1 && found_q) begin
				// close the gap left by the removed entry
				wr_en   = 1'b1;
				wr_addr = addr_s1 - AW'(1);
				wr_id   = rd_id_s1;
				wr_prio = rd_prio_s1;
			end
		end else begin
			// head read, ready for a peek
			rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[wr_addr]   <= wr_id;
			prio_mem[wr_addr] <= wr_prio;
		end
		if (rd_en) begin
			rd_id_s1   <= id_mem[rd_addr];
			rd_prio_s1 <= prio_mem[rd_addr];
		end
		addr_s1 <= rd_addr;
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			occ_q   <= '0;
			hole_q  <= '0;
			ptr_q   <= '0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= rd_en && (cmd.ins_run || cmd.rem_run);
			if (cmd.load_op) begin
				hole_q  <= occ_q[AW-1:0];
				ptr_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.ins_run && shift_ins) begin
					hole_q <= hole_q - AW'(1);
				end
				if (cmd.rem_run && rd_en) begin
					ptr_q <= ptr_q + CW'(1);
				end
				if (rem_match) begin
					found_q <= 1'b1;
				end
			end
			if (ins_done) begin
				occ_q <= occ_q + CW'(1);
			end else if (rem_done && found_q) begin
				occ_q <= occ_q - CW'(1);
			end
		end
	end

	// request fields and result
	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			op_id_q   <= entry_id;
			op_prio_q <= entry_priority;
			op_head_q <= (action_t'(action) == ACT_REM_HEAD);
		end
		if (cmd.res_full) begin
			res_status_q <= ST_FULL;
			res_id_q     <= entry_id;
			res_prio_q   <= entry_priority;
		end else if (cmd.res_empty) begin
			res_status_q <= ST_EMPTY;
			res_id_q     <= (action_t'(action) == ACT_REM_ID) ? entry_id : '0;
			res_prio_q   <= '0;
		end else if (cmd.res_peek) begin
			res_status_q <= ST_OK;
			res_id_q     <= rd_id_s1;
			res_prio_q   <= rd_prio_s1;
		end else if (ins_done) begin
			res_status_q <= ST_OK;
			res_id_q     <= op_id_q;
			res_prio_q   <= op_prio_q;
		end else if (rem_match) begin
			res_id_q   <= op_head_q ? rd_id_s1 : op_id_q;
			res_prio_q <= rd_prio_s1;
		end else if (rem_done) begin
			if (found_q) begin
				res_status_q <= ST_OK;
			end else begin
				res_status_q <= ST_NOT_FOUND;
				res_id_q     <= op_id_q;
				res_prio_q   <= '0;
			end
		end
		if (cmd.push_out) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_prio_q   <= res_prio_q;
			out_empty_q  <= (occ_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_out) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.full     = (occ_q == CW'(QUEUE_DEPTH));
	assign stat.empty    = (occ_q == '0);
	assign stat.ins_done = ins_done;
	assign stat.rem_done = rem_done;
	assign stat.out_free = !out_valid_q || res_ready;

	assign res_valid       = out_valid_q;
	assign status          = out_status_q;
	assign result_id       = out_id_q;
	assign result_priority = out_prio_q;
	assign queue_empty     = out_empty_q;

endmodule

// ----- rtl/priority_ordered_process_queue_unit.sv -----
// ----------------------------------------------------------------------------
// priority_ordered_process_queue_unit: sorted process queue
// keeps process identifiers in descending priority order, ties in arrival
// order; insert, remove head, remove by identifier and peek head
// ----------------------------------------------------------------------------
//
// channel   | handshake              | fields
// ----------+------------------------+------------------------------------------
// request   | req_valid / req_ready  | action, entry_id, entry_priority
// result    | res_valid / res_ready  | status, result_id, result_priority,
//           |                        | queue_empty
//
// one request at a time; one result per request
// insert and remove walk the slot memory one slot a cycle through its single
// read port; a peek reads the head slot, a full or empty answer needs no
// walk, and every request passes through the finish state back to idle
// a result waits in the output register while res_ready is low; the next
// request is taken once that result has been registered
// reset clears the occupancy count, walk state, output valid flag and sequencer state; slot contents need no clearing
//
module priority_ordered_process_queue_unit #(
	parameter int QUEUE_DEPTH   = poq_pkg::QUEUE_DEPTH_DEF,
	parameter int PRIORITY_BITS = poq_pkg::PRIORITY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [poq_pkg::ACTION_W-1:0]  action,
	input  logic [poq_pkg::ID_W-1:0]      entry_id,
	input  logic [PRIORITY_BITS-1:0]      entry_priority,
	// result channel
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [poq_pkg::STATUS_W-1:0]  status,
	output logic [poq_pkg::ID_W-1:0]      result_id,
	output logic [PRIORITY_BITS-1:0]      result_priority,
	output logic                          queue_empty
);
	import poq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: idle, insert or remove walk, peek, finish
	poq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action),
		.stat      (stat),
		.cmd       (cmd)
	);

	// slot memory, walk pointers, result and output registers
	poq_dp #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.action          (action),
		.entry_id        (entry_id),
		.entry_priority  (entry_priority),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.status          (status),
		.result_id       (result_id),
		.result_priority (result_priority),
		.queue_empty     (queue_empty)
	);

endmodule

// ----- rtl/poq_sva.sv -----
// ----------------------------------------------------------------------------
// poq_sva: port-level checks of the process queue
// request ordering and result consistency, attached by bind
// ----------------------------------------------------------------------------
module poq_sva #(
	parameter int PRIORITY_BITS = poq_pkg::PRIORITY_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [poq_pkg::STATUS_W-1:0]  status,
	input logic [poq_pkg::ID_W-1:0]      result_id,
	input logic [PRIORITY_BITS-1:0]      result_priority,
	input logic                          queue_empty
);
	import poq_pkg::*;

	// one request in flight: no second request right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// an empty answer leaves the queue empty
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_EMPTY) |-> queue_empty)
		else $error("empty status with non-empty queue");

	// full or not-found leave entries in the queue; not-found has no priority
	a_nonempty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_FULL || status == ST_NOT_FOUND) |-> !queue_empty)
		else $error("full or not-found status with empty queue");

	a_not_found_prio: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_NOT_FOUND) |-> (result_priority == '0))
		else $error("not-found result carries a priority");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status)
			&& $stable(result_id) && $stable(result_priority) && $stable(queue_empty))
		else $error("stalled result changed");

endmodule

bind priority_ordered_process_queue_unit poq_sva #(
	.PRIORITY_BITS (PRIORITY_BITS)
) u_poq_sva (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req_valid),
	.req_ready       (req_ready),
	.res_valid       (res_valid),
	.res_ready       (res_ready),
	.status          (status),
	.result_id       (result_id),
	.result_priority (result_priority),
	.queue_empty     (queue_empty)
);

// ----- verif/priority_ordered_process_queue_unit_tb.sv -----
// ----------------------------------------------------------------------------
// priority_ordered_process_queue_unit_tb: self-checking bench of the sorted
// process queue
// a shadow copy of the queue predicts every result; a directed opening covers
// the empty, tie, duplicate and absent cases, then random segments fill the
// queue past full and drain it past empty, with idle bursts on both channels
// ----------------------------------------------------------------------------
module priority_ordered_process_queue_unit_tb;

	import poq_pkg::*;

	localparam int DEPTH      = QUEUE_DEPTH_DEF;
	localparam int PBITS      = PRIORITY_BITS_DEF;
	localparam int N_RANDOM   = 1600;
	localparam int CALM_TAIL  = 200;      // segments starting in the last requests run with no idling
	localparam int SETTLE     = 40;       // longest walk plus the return to idle
	localparam int LIMIT      = 500000;   // cycles before the run is declared hung
	localparam int MAX_PRINTS = 40;

	typedef logic [ID_W-1:0]  id_t;
	typedef logic [PBITS-1:0] prio_t;

	// what one result should carry
	typedef struct {
		status_t st;
		id_t     id;
		prio_t   prio;
		logic    empty;
	} queue_result_t;

	// shadow of the queue contents plus the results still owed by the block
	class process_queue_shadow;
		id_t           slot_id [DEPTH];
		prio_t         slot_prio [DEPTH];
		int            fill;
		queue_result_t awaited[$];
		int            mismatches;
		int            checked;
		int            status_hits [4];

		function new();
			fill = 0;
			mismatches = 0;
			checked = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= MAX_PRINTS)
				$display("mismatch: %s", msg);
		endfunction

		// close the gap left by a removed slot
		function void drop(int pos);
			for (int k = pos; k < fill - 1; k++) begin
				slot_id[k]   = slot_id[k + 1];
				slot_prio[k] = slot_prio[k + 1];
			end
			fill--;
		endfunction

		function void note_request(action_t act, id_t id, prio_t prio);
			queue_result_t r;
			int pos;
			int k;
			bit found;
			r.st = ST_OK;
			r.id = '0;
			r.prio = '0;
			case (act)
				ACT_INSERT: begin
					r.id = id;
					r.prio = prio;
					if (fill >= DEPTH) begin
						r.st = ST_FULL;
					end else begin
						// in front of the first strictly lower priority
						pos = fill;
						for (k = 0; k < fill; k++) begin
							if (prio > slot_prio[k]) begin
								pos = k;
								break;
							end
						end
						for (k = fill; k > pos; k--) begin
							slot_id[k]   = slot_id[k - 1];
							slot_prio[k] = slot_prio[k - 1];
						end
						slot_id[pos] = id;
						slot_prio[pos] = prio;
						fill++;
					end
				end
				ACT_REM_HEAD, ACT_PEEK: begin
					if (fill == 0) begin
						r.st = ST_EMPTY;
					end else begin
						r.id = slot_id[0];
						r.prio = slot_prio[0];
						if (act == ACT_REM_HEAD)
							drop(0);
					end
				end
				default: begin
					r.id = id;
					if (fill == 0) begin
						r.st = ST_EMPTY;
					end else begin
						found = 0;
						pos = 0;
						for (k = 0; k < fill; k++) begin
							if (!found && slot_id[k] == id) begin
								found = 1;
								pos = k;
							end
						end
						if (found) begin
							r.prio = slot_prio[pos];
							drop(pos);
						end else begin
							r.st = ST_NOT_FOUND;
						end
					end
				end
			endcase
			r.empty = (fill == 0);
			status_hits[r.st]++;
			awaited.push_back(r);
		endfunction

		function void check_result(status_t st, id_t id, prio_t prio, logic empty);
			queue_result_t r;
			if (awaited.size() == 0) begin
				report($sformatf("result with no request outstanding: status %s id %0d",
					st.name(), id));
				return;
			end
			r = awaited.pop_front();
			checked++;
			if (st !== r.st)
				report($sformatf("status %s, expected %s", st.name(), r.st.name()));
			if (id !== r.id)
				report($sformatf("result_id %0d, expected %0d", id, r.id));
			if (prio !== r.prio)
				report($sformatf("result_priority %0d, expected %0d", prio, r.prio));
			if (empty !== r.empty)
				report($sformatf("queue_empty %0b, expected %0b", empty, r.empty));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	logic [ACTION_W-1:0] action;
	id_t                 entry_id;
	prio_t               entry_priority;
	logic                res_valid;
	logic                res_ready;
	logic [STATUS_W-1:0] status;
	id_t                 result_id;
	prio_t               result_priority;
	logic                queue_empty;

	process_queue_shadow shadow = new();

	int gap_pct;      // chance of a sender gap before a request
	int stall_pct;    // chance of a receiver stall burst
	int requests_sent;

	priority_ordered_process_queue_unit #(
		.QUEUE_DEPTH  (DEPTH),
		.PRIORITY_BITS(PBITS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.action         (action),
		.entry_id       (entry_id),
		.entry_priority (entry_priority),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.status         (status),
		.result_id      (result_id),
		.result_priority(result_priority),
		.queue_empty    (queue_empty)
	);

	// 10 unit period
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hang guard: runs out long after the slowest correct run would end
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results still owed", LIMIT,
			shadow.pending());
		$display("== FAIL ==");
		$finish;
	end

	// result side: ready drops in random bursts while stall_pct is nonzero
	initial begin
		res_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end else begin
				res_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// every accepted result is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			shadow.check_result(status_t'(status), result_id, result_priority,
				queue_empty);
	end

	// one request; called at a falling edge, returns at a falling edge
	task automatic send_request(action_t act, id_t id, prio_t prio);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		entry_id <= id;
		entry_priority <= prio;
		do @(posedge clk); while (!req_ready);
		// prediction follows the request order exactly
		shadow.note_request(act, id, prio);
		requests_sent++;
		@(negedge clk);
	endtask

	// hold off new requests until every owed result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (shadow.pending() > 0);
	endtask

	// priorities partly from a coarse grid or the top value give plenty of ties
	function automatic prio_t pick_priority();
		case ($urandom_range(0, 4))
			0:       return prio_t'($urandom_range(0, 7) << 5);
			1:       return {PBITS{1'b1}};
			default: return prio_t'($urandom_range(0, (1 << PBITS) - 1));
		endcase
	endfunction

	// mostly names an entry that is present, sometimes any identifier
	function automatic id_t pick_victim();
		if (shadow.fill > 0 && $urandom_range(0, 3) != 0)
			return shadow.slot_id[$urandom_range(0, shadow.fill - 1)];
		return id_t'($urandom_range(0, (1 << ID_W) - 1));
	endfunction

	initial begin
		int seg_len;
		int ins_pct;
		int r;
		action_t act;

		// known values on every input from time zero
		arst_n = 1'b0;
		req_valid = 1'b0;
		action = ACT_INSERT;
		entry_id = '0;
		entry_priority = '0;
		gap_pct = 0;
		stall_pct = 0;
		requests_sent = 0;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed opening
		// empty queue answers for every removal and for a peek
		send_request(ACT_PEEK, 5'd0, 8'd0);
		send_request(ACT_REM_HEAD, 5'd0, 8'd0);
		send_request(ACT_REM_ID, 5'd31, 8'd255);
		// field extremes, then ties that must keep arrival order
		send_request(ACT_INSERT, 5'd0, 8'd0);
		send_request(ACT_INSERT, 5'd31, 8'd255);
		send_request(ACT_INSERT, 5'd5, 8'd128);
		send_request(ACT_INSERT, 5'd6, 8'd128);
		send_request(ACT_INSERT, 5'd7, 8'd0);
		send_request(ACT_PEEK, 5'd0, 8'd0);
		// identifier that is not in the queue
		send_request(ACT_REM_ID, 5'd9, 8'd0);
		// duplicate identifier: the one nearer the head goes first
		send_request(ACT_INSERT, 5'd5, 8'd10);
		send_request(ACT_REM_ID, 5'd5, 8'd0);
		send_request(ACT_REM_ID, 5'd5, 8'd0);
		send_request(ACT_REM_HEAD, 5'd0, 8'd0);
		// tail entry by identifier, then drain to empty
		send_request(ACT_REM_ID, 5'd7, 8'd0);
		send_request(ACT_REM_HEAD, 5'd0, 8'd0);
		send_request(ACT_REM_HEAD, 5'd0, 8'd0);
		send_request(ACT_REM_HEAD, 5'd0, 8'd0);
		// alternating bit patterns
		send_request(ACT_INSERT, 5'd21, 8'd170);
		send_request(ACT_INSERT, 5'd10, 8'd85);
		send_request(ACT_REM_ID, 5'd10, 8'd0);
		send_request(ACT_REM_HEAD, 5'd0, 8'd0);
		send_request(ACT_PEEK, 5'd0, 8'd0);

		// sender waits out every owed result at least once
		wait_drained();

		// random segments: each leans toward filling, draining or neither
		while (requests_sent < N_RANDOM) begin
			seg_len = $urandom_range(40, 160);
			case ($urandom_range(0, 2))
				0:       ins_pct = 85;
				1:       ins_pct = 15;
				default: ins_pct = 50;
			endcase
			if (requests_sent >= N_RANDOM - CALM_TAIL) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0:       gap_pct = 0;
					1:       gap_pct = 10;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 10;
					default: stall_pct = 40;
				endcase
			end
			for (int n = 0; n < seg_len && requests_sent < N_RANDOM; n++) begin
				r = $urandom_range(0, 99);
				if (r < ins_pct) begin
					send_request(ACT_INSERT, id_t'($urandom_range(0, 31)), pick_priority());
				end else begin
					r = $urandom_range(0, 99);
					if (r < 45)
						act = ACT_REM_ID;
					else if (r < 85)
						act = ACT_REM_HEAD;
					else
						act = ACT_PEEK;
					send_request(act, (act == ACT_REM_ID) ? pick_victim()
						: id_t'($urandom_range(0, 31)), pick_priority());
				end
			end
			// now and then a full drain between segments
			if ($urandom_range(0, 2) == 0)
				wait_drained();
		end

		// all requests in: collect what is owed, then watch for strays
		req_valid <= 1'b0;
		do @(negedge clk); while (shadow.pending() > 0);
		repeat (SETTLE) @(negedge clk);

		if (shadow.pending() > 0)
			shadow.report($sformatf("%0d results never arrived", shadow.pending()));

		$display("ran %0d requests, checked %0d results, %0d mismatches",
			requests_sent, shadow.checked, shadow.mismatches);
		$display("answers seen: ok %0d, empty %0d, not found %0d, full %0d",
			shadow.status_hits[ST_OK], shadow.status_hits[ST_EMPTY],
			shadow.status_hits[ST_NOT_FOUND], shadow.status_hits[ST_FULL]);
		if (shadow.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
